// ===== sv/sorted_priority_queue_unit_macros.svh =====
// Assertion helpers for the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication, clocked on aclk, off during reset.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

// ===== sv/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH       = 8;
    localparam int PRIO_WIDTH  = 8;
    localparam int VALUE_WIDTH = 16;
    localparam int OCC_WIDTH   = 4;
    localparam int CNT_WIDTH   = $clog2(DEPTH + 1);

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [1:0] ST_ENQUEUED  = 2'd0;
    localparam logic [1:0] ST_DELIVERED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [PRIO_WIDTH-1:0]  prio;
        logic [VALUE_WIDTH-1:0] value;
    } slot_t;

    // Broadcast to every cell each cycle.
    typedef struct packed {
        logic  enq;
        logic  deq;
        slot_t entry;
    } cell_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell import spq_pkg::*; (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  logic      slot_valid,
    input  logic      left_shift,
    input  slot_t     left_slot,
    input  slot_t     right_slot,
    output logic      shift,
    output slot_t     slot
);

    slot_t slot_reg;
    slot_t slot_next;

    // Empty slots and slots with a larger number make room for the new entry.
    assign shift = !slot_valid || (slot_reg.prio > cmd.entry.prio);
    assign slot  = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (cmd.enq && shift) begin
            // left neighbor also moves back: take its entry, else the new one lands here
            slot_next = left_shift ? left_slot : cmd.entry;
        end else if (cmd.deq) begin
            slot_next = right_slot;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

endmodule

// ===== sv/sorted_priority_queue_unit.sv =====
// Sorted priority queue, one cell per slot, head in cell 0.
// The result is registered and shows the cycle after the request is accepted.
// One request per cycle while results drain; cells compare and shift together.
// Reset: synchronous active-low aresetn clears entry count and output valid;
// slot contents are not reset and are only read below the entry count.
`include "sorted_priority_queue_unit_macros.svh"

module sorted_priority_queue_unit import spq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_operation,
    input  logic [PRIO_WIDTH-1:0]  s_entry_priority,
    input  logic [VALUE_WIDTH-1:0] s_entry_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [VALUE_WIDTH-1:0] m_out_value,
    output logic [1:0]             m_status,
    output logic [OCC_WIDTH-1:0]   m_occupancy
);

    logic                   in_fire;
    logic                   is_full;
    logic                   is_empty;
    cell_cmd_t              cmd;
    logic [CNT_WIDTH-1:0]   count_reg;
    logic [CNT_WIDTH-1:0]   count_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [VALUE_WIDTH-1:0] m_value_reg;
    logic [VALUE_WIDTH-1:0] m_value_next;
    logic [1:0]             m_status_reg;
    logic [1:0]             m_status_next;
    logic [OCC_WIDTH-1:0]   m_occ_reg;
    logic [OCC_WIDTH-1:0]   m_occ_next;

    slot_t                  slots [DEPTH];
    logic  [DEPTH-1:0]      shifts;

    // Output register frees up whenever the downstream takes it.
    assign s_ready  = !m_valid_reg || m_ready;
    assign in_fire  = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_WIDTH'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb begin
        cmd.enq         = in_fire && (s_operation == OP_ENQ) && !is_full;
        cmd.deq         = in_fire && (s_operation == OP_DEQ) && !is_empty;
        cmd.entry.prio  = s_entry_priority;
        cmd.entry.value = s_entry_value;
    end

    // Cell row: valid slots are those below the entry count.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .slot_valid (CNT_WIDTH'(i) < count_reg),
            .left_shift ((i == 0) ? 1'b0 : shifts[(i == 0) ? 0 : i - 1]),
            .left_slot  ((i == 0) ? cmd.entry : slots[(i == 0) ? 0 : i - 1]),
            .right_slot ((i == DEPTH - 1) ? slots[i] : slots[(i == DEPTH - 1) ? i : i + 1]),
            .shift      (shifts[i]),
            .slot       (slots[i])
        );
    end

    always_comb begin
        count_next    = count_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        if (cmd.enq) begin
            count_next = count_reg + CNT_WIDTH'(1);
        end else if (cmd.deq) begin
            count_next = count_reg - CNT_WIDTH'(1);
        end
        if (in_fire) begin
            m_valid_next = 1'b1;
            m_value_next = '0;
            if (s_operation == OP_ENQ) begin
                m_status_next = is_full ? ST_FULL : ST_ENQUEUED;
            end else if (is_empty) begin
                m_status_next = ST_EMPTY;
            end else begin
                m_status_next = ST_DELIVERED;
                m_value_next  = slots[0].value;
            end
        end
        m_occ_next = in_fire ? OCC_WIDTH'(count_next) : m_occ_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_value_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occ_reg;

    // checks
    `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_WIDTH'(DEPTH))
    `SPQ_ASSERT_NEXT(a_enq_count, cmd.enq, count_reg == $past(count_reg) + CNT_WIDTH'(1))
    `SPQ_ASSERT_NOW(a_head_order, count_reg >= CNT_WIDTH'(2), slots[0].prio <= slots[1].prio)
    `SPQ_ASSERT_NOW(a_value_zero, m_valid && (m_status != ST_DELIVERED), m_out_value == '0)

endmodule

// ===== tb/spq_checker.sv =====
module spq_checker import spq_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_operation,
    input  logic [PRIO_WIDTH-1:0]  s_entry_priority,
    input  logic [VALUE_WIDTH-1:0] s_entry_value,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [VALUE_WIDTH-1:0] m_out_value,
    input  logic [1:0]             m_status,
    input  logic [OCC_WIDTH-1:0]   m_occupancy,
    output int                     mismatch_count,
    output int                     pending_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VALUE_WIDTH-1:0] value;
        logic [1:0]             status;
        logic [OCC_WIDTH-1:0]   occupancy;
    } outcome_t;

    outcome_t               expected_outcomes[$];
    logic [PRIO_WIDTH-1:0]  held_prio[DEPTH];
    logic [VALUE_WIDTH-1:0] held_value[DEPTH];
    int                     held_count = 0;
    int                     errors = 0;

    // Sorted insert behind equal priorities; dequeue pops slot 0.
    function automatic outcome_t apply_queue_request(input logic op,
                                                     input logic [PRIO_WIDTH-1:0] prio,
                                                     input logic [VALUE_WIDTH-1:0] value);
        outcome_t o;
        int       pos;
        o.value = '0;
        if (op == OP_ENQ) begin
            if (held_count >= DEPTH) begin
                o.status = ST_FULL;
            end else begin
                pos = held_count;
                while (pos > 0 && held_prio[pos-1] > prio) begin
                    held_prio[pos]  = held_prio[pos-1];
                    held_value[pos] = held_value[pos-1];
                    pos--;
                end
                held_prio[pos]  = prio;
                held_value[pos] = value;
                held_count++;
                o.status = ST_ENQUEUED;
            end
        end else begin
            if (held_count == 0) begin
                o.status = ST_EMPTY;
            end else begin
                o.value = held_value[0];
                for (int i = 1; i < held_count; i++) begin
                    held_prio[i-1]  = held_prio[i];
                    held_value[i-1] = held_value[i];
                end
                held_count--;
                o.status = ST_DELIVERED;
            end
        end
        o.occupancy = OCC_WIDTH'(held_count);
        return o;
    endfunction

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        outcome_t oldest;
        if (!aresetn) begin
            expected_outcomes.delete();
            held_count = 0;
        end else begin
            // compare first: a result leaving now belongs to an older request
            if (m_valid && m_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got value %0h status %0d",
                             $time, m_out_value, m_status);
                    errors++;
                end else begin
                    oldest = expected_outcomes.pop_front();
                    check_field("out_value", 64'(oldest.value), 64'(m_out_value));
                    check_field("status", 64'(oldest.status), 64'(m_status));
                    check_field("occupancy", 64'(oldest.occupancy), 64'(m_occupancy));
                end
            end
            if (s_valid && s_ready)
                expected_outcomes.push_back(
                    apply_queue_request(s_operation, s_entry_priority, s_entry_value));
        end
        mismatch_count <= errors;
        pending_count  <= expected_outcomes.size();
    end

endmodule

// ===== tb/testbench.sv =====
module testbench;

    import spq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Shapes of the priority stream within one random phase.
    typedef enum logic [1:0] {
        PRIO_TIES,     // few distinct numbers, many equal priorities
        PRIO_SPREAD,   // anything in range
        PRIO_EXTREME   // only the lowest and highest number
    } prio_style_e;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_operation = OP_ENQ;
    logic [PRIO_WIDTH-1:0]  s_entry_priority = '0;
    logic [VALUE_WIDTH-1:0] s_entry_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [VALUE_WIDTH-1:0] m_out_value;
    logic [1:0]             m_status;
    logic [OCC_WIDTH-1:0]   m_occupancy;

    int mismatch_count;
    int pending_count;
    bit calm = 1'b0;    // when set, neither side idles

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_priority_queue_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_entry_priority (s_entry_priority),
        .s_entry_value    (s_entry_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_value      (m_out_value),
        .m_status         (m_status),
        .m_occupancy      (m_occupancy)
    );

    spq_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_entry_priority (s_entry_priority),
        .s_entry_value    (s_entry_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_value      (m_out_value),
        .m_status         (m_status),
        .m_occupancy      (m_occupancy),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    // Idle cycles before the next request or result: none when calm, else often none and otherwise drawn at random.
    function automatic int draw_wait();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 12);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    // With no gap, valid stays high and only the payload changes.
    task automatic push_request(input logic op, input logic [PRIO_WIDTH-1:0] prio,
                                input logic [VALUE_WIDTH-1:0] value);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_operation      <= op;
        s_entry_priority <= prio;
        s_entry_value    <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and wait until every request has been answered.
    // pending_count is registered, so it is read only after an edge, once the last request is counted.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    // Result side: a fresh stall for every result.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        prio_style_e            style;
        int                     enq_pct;
        logic                   op;
        logic [PRIO_WIDTH-1:0]  prio;
        logic [VALUE_WIDTH-1:0] value;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty reject, fill with extremes and ties, full reject,
        // drain in priority order, empty reject again.
        push_request(OP_DEQ, 8'hff, 16'hffff);
        push_request(OP_ENQ, 8'hff, 16'hffff);
        push_request(OP_ENQ, 8'h00, 16'h0000);
        push_request(OP_ENQ, 8'h80, 16'haaaa);
        push_request(OP_ENQ, 8'h80, 16'h5555);   // tie: must leave after 16'haaaa
        push_request(OP_ENQ, 8'h00, 16'h1234);   // tie at the head
        push_request(OP_ENQ, 8'hff, 16'h0001);   // tie at the tail
        push_request(OP_ENQ, 8'h7f, 16'h8000);
        push_request(OP_ENQ, 8'h01, 16'h7fff);   // queue now full
        push_request(OP_ENQ, 8'h00, 16'hbeef);   // full reject, even at top priority
        repeat (8) push_request(OP_DEQ, 8'h00, 16'h0000);
        push_request(OP_DEQ, 8'h55, 16'ha5a5);

        // Sender waits out every outstanding result at least once.
        hold_until_drained();

        // Random phases: each picks an enqueue share and a priority shape,
        // so the queue swings between empty and full with varied ordering.
        for (int phase = 0; phase < 32; phase++) begin
            case ($urandom_range(0, 2))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                default: enq_pct = 75;
            endcase
            style = prio_style_e'($urandom_range(0, 2));
            calm  = ($urandom_range(0, 3) == 0);
            repeat (39) begin
                op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
                case (style)
                    PRIO_TIES:    prio = PRIO_WIDTH'($urandom_range(0, 3));
                    PRIO_EXTREME: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
                    default:      prio = PRIO_WIDTH'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 9) == 0)
                    value = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                else
                    value = VALUE_WIDTH'($urandom_range(0, 65535));
                push_request(op, prio, value);
            end
            if ($urandom_range(0, 3) == 0)
                hold_until_drained();
        end
        calm = 1'b0;

        hold_until_drained();
        // a few more edges to catch any stray result
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Hang guard, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue_unit.sv
tb/spq_checker.sv
tb/testbench.sv
